// ===== hdl/per_cpu_page_free_list_allocator_unit_assert.svh =====
// assertion macros for the page allocator
// no dependencies; expects clk and arst_n in the including module
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PCA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PCA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PCA_ASSERT_IMP(lbl, ante, cons, msg)
`define PCA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/pca_pkg.sv =====
// shared constants, codes and state type of the page allocator
// no dependencies
`default_nettype none
package pca_pkg;

	localparam int NUM_REQUESTERS = 8;
	localparam int NUM_PAGES      = 1024;
	localparam int PAGE_BYTES     = 4096;

	localparam int ADDR_W    = 40;
	localparam int REQ_W     = 3;
	localparam int KIND_W    = 1;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int PG_SHIFT = $clog2(PAGE_BYTES);
	localparam int PG_W     = $clog2(NUM_PAGES);
	localparam int LINK_W   = $clog2(NUM_PAGES + 1);
	localparam int BASE_W   = ADDR_W - PG_SHIFT + 1;
	localparam int RQ_IDX_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
	localparam int VC_W     = $clog2(NUM_REQUESTERS + 1);

	localparam logic [LINK_W-1:0] NIL_PAGE = LINK_W'(NUM_PAGES);
	localparam logic [ADDR_W-1:0] REGION_END_RST = 40'h00_8800_0000;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_FREE_CHK,
		S_POP_WAIT,
		S_SCAN,
		S_SCAN_WAIT,
		S_SPLIT_X,
		S_SPLIT_Y,
		S_SPLIT_LAST,
		S_POP_ISSUE,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/pca_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module pca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/per_cpu_page_free_list_allocator_unit.sv =====
// per-requester free-list page allocator with list splitting on empty alloc
// depends on pca_pkg, pca_ram and per_cpu_page_free_list_allocator_unit_assert.svh
//
// channel  direction  handshake               payload
// in       to block   in_valid / in_ready     kind, requester, page_address
// out      from block out_valid / out_ready   status, granted_address
// cfg      to block   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a free goes S_DECODE, S_FREE_CHK, S_RESP, a direct pop S_DECODE, S_POP_WAIT, S_RESP;
// no new transaction until S_IDLE; a free that fails the address checks skips S_FREE_CHK
// a steal walks S_SCAN for each requester skipped, plus S_SCAN_WAIT for a single-page
// one; the victim adds S_SCAN_WAIT, S_SPLIT_X/Y per page of its list via the one link
// ram read port, S_SPLIT_LAST, S_POP_ISSUE, S_POP_WAIT; after reset clearing all
// NUM_PAGES (1024) free bits keeps in_ready low; a full output register stalls S_RESP
`default_nettype none
module per_cpu_page_free_list_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pca_pkg::KIND_W-1:0]     kind,
	input  logic [pca_pkg::REQ_W-1:0]      requester,
	input  logic [pca_pkg::ADDR_W-1:0]     page_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pca_pkg::STATUS_W-1:0]   status,
	output logic [pca_pkg::ADDR_W-1:0]     granted_address,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pca_pkg::ADDR_W-1:0]     cfg_data
);

	`include "per_cpu_page_free_list_allocator_unit_assert.svh"

	pca_pkg::state_t state_q, state_d;

	logic [pca_pkg::ADDR_W-1:0]   region_start_q, region_end_q;
	logic [pca_pkg::BASE_W-1:0]   base_pg_q;

	logic [pca_pkg::KIND_W-1:0]   kind_q;
	logic [pca_pkg::REQ_W-1:0]    req_q;
	logic [pca_pkg::ADDR_W-1:0]   pa_q;

	logic [pca_pkg::LINK_W-1:0]   head_q [pca_pkg::NUM_REQUESTERS];
	logic [pca_pkg::PG_W-1:0]     idx_q, p_q, thief_q, clr_q;
	logic [pca_pkg::LINK_W-1:0]   x_q, y_q;
	logic [pca_pkg::VC_W-1:0]     v_q;
	logic [pca_pkg::STATUS_W-1:0] res_status_q;

	logic                         out_valid_q;
	logic [pca_pkg::STATUS_W-1:0] status_q;
	logic [pca_pkg::ADDR_W-1:0]   granted_q;

	logic [pca_pkg::RQ_IDX_W-1:0] hd_raddr, hd_waddr;
	logic [pca_pkg::LINK_W-1:0]   hd_rdata, hd_wdata;
	logic                         hd_we;

	logic                         link_we, link_re;
	logic [pca_pkg::PG_W-1:0]     link_waddr, link_raddr;
	logic [pca_pkg::LINK_W-1:0]   link_wdata, link_rdata;
	logic                         free_we, free_re;
	logic [pca_pkg::PG_W-1:0]     free_waddr, free_raddr;
	logic [0:0]                   free_wdata, free_rdata;

	logic                         req_ok, aligned, ge_start, lt_end, ge_base, in_range;
	logic                         free_ok, is_free, hd_empty, v_done, v_skip, link_nil;
	logic                         out_slot;
	logic [pca_pkg::BASE_W-1:0]   pa_pg, off, grant_pg;
	logic [pca_pkg::ADDR_W-1:0]   grant_addr;

	pca_ram #(
		.WIDTH(pca_pkg::LINK_W),
		.DEPTH(pca_pkg::NUM_PAGES)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (link_re),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	pca_ram #(
		.WIDTH(1),
		.DEPTH(pca_pkg::NUM_PAGES)
	) u_free_ram (
		.clk  (clk),
		.we   (free_we),
		.waddr(free_waddr),
		.wdata(free_wdata),
		.re   (free_re),
		.raddr(free_raddr),
		.rdata(free_rdata)
	);

	assign hd_raddr = (state_q == pca_pkg::S_SCAN) ? v_q[pca_pkg::RQ_IDX_W-1:0]
		: pca_pkg::RQ_IDX_W'(req_q);
	assign hd_rdata = head_q[hd_raddr];
	assign hd_waddr = pca_pkg::RQ_IDX_W'(req_q);

	assign req_ok   = {1'b0, req_q} < (pca_pkg::REQ_W + 1)'(pca_pkg::NUM_REQUESTERS);
	assign aligned  = pa_q[pca_pkg::PG_SHIFT-1:0] == '0;
	assign ge_start = pa_q >= region_start_q;
	assign lt_end   = pa_q < region_end_q;
	assign pa_pg    = {1'b0, pa_q[pca_pkg::ADDR_W-1:pca_pkg::PG_SHIFT]};
	assign ge_base  = pa_pg >= base_pg_q;
	assign off      = pa_pg - base_pg_q;
	assign in_range = off < pca_pkg::BASE_W'(pca_pkg::NUM_PAGES);
	assign free_ok  = req_ok && aligned && ge_start && lt_end && ge_base && in_range;
	assign is_free  = kind_q == pca_pkg::KIND_FREE;

	assign hd_empty = hd_rdata == pca_pkg::NIL_PAGE;
	assign v_done   = v_q == pca_pkg::VC_W'(pca_pkg::NUM_REQUESTERS);
	assign v_skip   = (v_q == pca_pkg::VC_W'(req_q)) || hd_empty;
	assign link_nil = link_rdata == pca_pkg::NIL_PAGE;
	assign out_slot = !out_valid_q || out_ready;

	assign grant_pg   = base_pg_q + pca_pkg::BASE_W'(p_q);
	assign grant_addr = {grant_pg[pca_pkg::ADDR_W-pca_pkg::PG_SHIFT-1:0],
		{pca_pkg::PG_SHIFT{1'b0}}};

	assign in_ready        = state_q == pca_pkg::S_IDLE;
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pca_pkg::S_CLEAR: begin
				if (clr_q == pca_pkg::PG_W'(pca_pkg::NUM_PAGES - 1)) begin
					state_d = pca_pkg::S_IDLE;
				end
			end
			pca_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = pca_pkg::S_DECODE;
				end
			end
			pca_pkg::S_DECODE: begin
				if (is_free) begin
					state_d = free_ok ? pca_pkg::S_FREE_CHK : pca_pkg::S_RESP;
				end else if (!req_ok) begin
					state_d = pca_pkg::S_RESP;
				end else begin
					state_d = hd_empty ? pca_pkg::S_SCAN : pca_pkg::S_POP_WAIT;
				end
			end
			pca_pkg::S_FREE_CHK: state_d = pca_pkg::S_RESP;
			pca_pkg::S_POP_WAIT: state_d = pca_pkg::S_RESP;
			pca_pkg::S_SCAN: begin
				if (v_done) begin
					state_d = pca_pkg::S_RESP;
				end else if (!v_skip) begin
					state_d = pca_pkg::S_SCAN_WAIT;
				end
			end
			pca_pkg::S_SCAN_WAIT: state_d = link_nil ? pca_pkg::S_SCAN : pca_pkg::S_SPLIT_X;
			pca_pkg::S_SPLIT_X: state_d = link_nil ? pca_pkg::S_SPLIT_LAST : pca_pkg::S_SPLIT_Y;
			pca_pkg::S_SPLIT_Y: state_d = link_nil ? pca_pkg::S_SPLIT_LAST : pca_pkg::S_SPLIT_X;
			pca_pkg::S_SPLIT_LAST: state_d = pca_pkg::S_POP_ISSUE;
			pca_pkg::S_POP_ISSUE: state_d = pca_pkg::S_POP_WAIT;
			pca_pkg::S_RESP: begin
				if (out_slot) begin
					state_d = pca_pkg::S_IDLE;
				end
			end
			default: state_d = pca_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = x_q[pca_pkg::PG_W-1:0];
		link_wdata = link_rdata;
		link_re    = 1'b0;
		link_raddr = link_rdata[pca_pkg::PG_W-1:0];
		free_we    = 1'b0;
		free_waddr = p_q;
		free_wdata = 1'b0;
		free_re    = 1'b0;
		free_raddr = off[pca_pkg::PG_W-1:0];
		hd_we      = 1'b0;
		hd_wdata   = link_rdata;
		unique case (state_q)
			pca_pkg::S_CLEAR: begin
				free_we    = 1'b1;
				free_waddr = clr_q;
			end
			pca_pkg::S_DECODE: begin
				free_re = is_free && free_ok;
				if (!is_free && req_ok && !hd_empty) begin
					link_re    = 1'b1;
					link_raddr = hd_rdata[pca_pkg::PG_W-1:0];
				end
			end
			pca_pkg::S_FREE_CHK: begin
				if (!free_rdata[0]) begin
					link_we    = 1'b1;
					link_waddr = idx_q;
					link_wdata = hd_rdata;
					free_we    = 1'b1;
					free_waddr = idx_q;
					free_wdata = 1'b1;
					hd_we      = 1'b1;
					hd_wdata   = {1'b0, idx_q};
				end
			end
			pca_pkg::S_POP_WAIT: begin
				hd_we   = 1'b1;
				free_we = 1'b1;
			end
			pca_pkg::S_SCAN: begin
				if (!v_done && !v_skip) begin
					link_re    = 1'b1;
					link_raddr = hd_rdata[pca_pkg::PG_W-1:0];
				end
			end
			pca_pkg::S_SCAN_WAIT: link_re = !link_nil;
			pca_pkg::S_SPLIT_X: begin
				link_we = 1'b1;
				link_re = !link_nil;
			end
			pca_pkg::S_SPLIT_Y: begin
				link_we    = 1'b1;
				link_waddr = y_q[pca_pkg::PG_W-1:0];
				link_re    = !link_nil;
			end
			pca_pkg::S_SPLIT_LAST: begin
				link_we    = 1'b1;
				link_wdata = pca_pkg::NIL_PAGE;
			end
			pca_pkg::S_POP_ISSUE: begin
				link_re    = 1'b1;
				link_raddr = thief_q;
			end
			pca_pkg::S_IDLE, pca_pkg::S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pca_pkg::S_CLEAR;
			clr_q          <= '0;
			v_q            <= '0;
			out_valid_q    <= 1'b0;
			region_start_q <= '0;
			region_end_q   <= pca_pkg::REGION_END_RST;
			base_pg_q      <= '0;
			for (int i = 0; i < pca_pkg::NUM_REQUESTERS; i++) begin
				head_q[i] <= pca_pkg::NIL_PAGE;
			end
		end else begin
			state_q <= state_d;
			if (state_q == pca_pkg::S_CLEAR) begin
				clr_q <= clr_q + pca_pkg::PG_W'(1);
			end
			if (hd_we) begin
				head_q[hd_waddr] <= hd_wdata;
			end
			if (state_q == pca_pkg::S_DECODE) begin
				v_q <= '0;
			end else if ((state_q == pca_pkg::S_SCAN && !v_done && v_skip) ||
				(state_q == pca_pkg::S_SCAN_WAIT && link_nil)) begin
				v_q <= v_q + pca_pkg::VC_W'(1);
			end
			if (state_q == pca_pkg::S_RESP && out_slot) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_index == pca_pkg::CFG_REGION_START) begin
				region_start_q <= cfg_data;
				base_pg_q      <= pca_pkg::BASE_W'(cfg_data[pca_pkg::ADDR_W-1:pca_pkg::PG_SHIFT])
					+ pca_pkg::BASE_W'(|cfg_data[pca_pkg::PG_SHIFT-1:0]);
			end
			if (cfg_valid && cfg_index == pca_pkg::CFG_REGION_END) begin
				region_end_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pca_pkg::S_IDLE: begin
				if (in_valid) begin
					kind_q <= kind;
					req_q  <= requester;
					pa_q   <= page_address;
				end
			end
			pca_pkg::S_DECODE: begin
				idx_q <= off[pca_pkg::PG_W-1:0];
				p_q   <= hd_rdata[pca_pkg::PG_W-1:0];
				res_status_q <= is_free ? pca_pkg::ST_REJECTED : pca_pkg::ST_NO_PAGE;
			end
			pca_pkg::S_FREE_CHK: begin
				res_status_q <= free_rdata[0] ? pca_pkg::ST_REJECTED : pca_pkg::ST_FREED;
			end
			pca_pkg::S_POP_WAIT: res_status_q <= pca_pkg::ST_ALLOCATED;
			pca_pkg::S_SCAN: begin
				if (v_done) begin
					res_status_q <= pca_pkg::ST_NO_PAGE;
				end else if (!v_skip) begin
					x_q <= hd_rdata;
				end
			end
			pca_pkg::S_SCAN_WAIT: begin
				if (!link_nil) begin
					thief_q <= link_rdata[pca_pkg::PG_W-1:0];
					y_q     <= link_rdata;
				end
			end
			pca_pkg::S_SPLIT_X: x_q <= link_nil ? y_q : link_rdata;
			pca_pkg::S_SPLIT_Y: y_q <= link_rdata;
			pca_pkg::S_POP_ISSUE: p_q <= thief_q;
			pca_pkg::S_RESP: begin
				if (out_slot) begin
					status_q  <= res_status_q;
					granted_q <= (res_status_q == pca_pkg::ST_ALLOCATED) ? grant_addr : '0;
				end
			end
			pca_pkg::S_CLEAR, pca_pkg::S_SPLIT_LAST: begin
			end
			default: begin
			end
		endcase
	end

	`PCA_ASSERT_IMP(a_link_no_collide, link_we && link_re, link_waddr != link_raddr,
		"link ram read and written at the same entry")
	`PCA_ASSERT_IMP(a_split_x_listed, state_q == pca_pkg::S_SPLIT_X ||
		state_q == pca_pkg::S_SPLIT_Y || state_q == pca_pkg::S_SPLIT_LAST,
		x_q != pca_pkg::NIL_PAGE, "split walk lost its victim cursor")
	`PCA_ASSERT_NXT(a_out_from_resp, !out_valid_q && state_q != pca_pkg::S_RESP,
		!out_valid_q, "result shown without a finished transaction")
	`PCA_ASSERT_IMP(a_grant_zero, out_valid_q && status_q != pca_pkg::ST_ALLOCATED,
		granted_q == '0, "address given for a failed transaction")

endmodule
`default_nettype wire

// ===== test/tb_per_cpu_page_free_list_allocator_unit.sv =====
// self-checking bench for the per-cpu page free-list allocator: directed and random
// alloc/free traffic over several region settings, checked against a free-list mirror
// depends on pca_pkg and per_cpu_page_free_list_allocator_unit
`timescale 1ns / 1ps
module tb_per_cpu_page_free_list_allocator_unit;

	localparam int IDLE_LIMIT = 20000;
	localparam logic [pca_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [pca_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [pca_pkg::STATUS_W-1:0] status;
		logic [pca_pkg::ADDR_W-1:0]   addr;
	} alloc_reply_t;

	class free_list_mirror;
		logic [pca_pkg::ADDR_W-1:0] region_start;
		logic [pca_pkg::ADDR_W-1:0] region_end;
		logic [pca_pkg::LINK_W-1:0] head [pca_pkg::NUM_REQUESTERS];
		logic [pca_pkg::LINK_W-1:0] link [pca_pkg::NUM_PAGES];
		bit                         listed [pca_pkg::NUM_PAGES];
		alloc_reply_t               replies [$];
		int                         errors;

		function new();
			region_start = '0;
			region_end = pca_pkg::REGION_END_RST;
			foreach (head[i]) head[i] = pca_pkg::NIL_PAGE;
			foreach (link[i]) link[i] = '0;
			foreach (listed[i]) listed[i] = 1'b0;
			errors = 0;
		endfunction

		function longint unsigned base();
			return ((64'(region_start) + pca_pkg::PAGE_BYTES - 1) / pca_pkg::PAGE_BYTES)
				* pca_pkg::PAGE_BYTES;
		endfunction

		function int outstanding();
			return replies.size();
		endfunction

		function void set_register(logic [pca_pkg::CFG_IDX_W-1:0] idx,
				logic [pca_pkg::ADDR_W-1:0] data);
			if (idx == pca_pkg::CFG_REGION_START) begin
				region_start = data;
			end else if (idx == pca_pkg::CFG_REGION_END) begin
				region_end = data;
			end
		endfunction

		function logic [pca_pkg::LINK_W-1:0] next_of(logic [pca_pkg::LINK_W-1:0] p);
			return (p < pca_pkg::NIL_PAGE) ? link[p[pca_pkg::PG_W-1:0]] : pca_pkg::NIL_PAGE;
		endfunction

		// victim keeps even positions, odd chain goes to the thief
		function logic [pca_pkg::LINK_W-1:0] split_off(int victim);
			logic [pca_pkg::LINK_W-1:0] x, y, nx, ny, thief;
			int guard;
			x = head[victim];
			y = next_of(x);
			thief = y;
			guard = 0;
			while (x < pca_pkg::NIL_PAGE && guard <= pca_pkg::NUM_PAGES) begin
				nx = next_of(y);
				link[x[pca_pkg::PG_W-1:0]] = nx;
				if (y < pca_pkg::NIL_PAGE) begin
					ny = next_of(nx);
					link[y[pca_pkg::PG_W-1:0]] = ny;
					y = ny;
				end
				x = nx;
				guard++;
			end
			return thief;
		endfunction

		function void note_request(logic [pca_pkg::KIND_W-1:0] k,
				logic [pca_pkg::REQ_W-1:0] r, logic [pca_pkg::ADDR_W-1:0] pa);
			longint unsigned b, idx;
			logic [pca_pkg::LINK_W-1:0] p;
			alloc_reply_t reply;
			b = base();
			reply.status = pca_pkg::ST_REJECTED;
			reply.addr = '0;
			if (k == pca_pkg::KIND_FREE) begin
				if (pa[pca_pkg::PG_SHIFT-1:0] == '0 && pa >= region_start &&
						pa < region_end && 64'(pa) >= b) begin
					idx = (64'(pa) - b) / pca_pkg::PAGE_BYTES;
					if (idx < pca_pkg::NUM_PAGES && !listed[idx]) begin
						link[idx] = head[r];
						head[r] = pca_pkg::LINK_W'(idx);
						listed[idx] = 1'b1;
						reply.status = pca_pkg::ST_FREED;
					end
				end
			end else begin
				if (head[r] >= pca_pkg::NIL_PAGE) begin
					for (int v = 0; v < pca_pkg::NUM_REQUESTERS; v++) begin
						if (v != r && head[v] < pca_pkg::NIL_PAGE &&
								next_of(head[v]) < pca_pkg::NIL_PAGE) begin
							head[r] = split_off(v);
							break;
						end
					end
				end
				p = head[r];
				if (p >= pca_pkg::NIL_PAGE) begin
					reply.status = pca_pkg::ST_NO_PAGE;
				end else begin
					head[r] = link[p[pca_pkg::PG_W-1:0]];
					listed[p[pca_pkg::PG_W-1:0]] = 1'b0;
					reply.status = pca_pkg::ST_ALLOCATED;
					reply.addr = pca_pkg::ADDR_W'(b + 64'(p) * pca_pkg::PAGE_BYTES);
				end
			end
			replies.push_back(reply);
		endfunction

		function void check_response(logic [pca_pkg::STATUS_W-1:0] st,
				logic [pca_pkg::ADDR_W-1:0] ga);
			alloc_reply_t want;
			if (replies.size() == 0) begin
				$error("result with no transaction pending: status %0d granted_address %h",
					st, ga);
				errors++;
				return;
			end
			want = replies.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (ga !== want.addr) begin
				$error("granted_address: expected %h, actual %h", want.addr, ga);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [pca_pkg::KIND_W-1:0]    kind = pca_pkg::KIND_ALLOC;
	logic [pca_pkg::REQ_W-1:0]     requester = '0;
	logic [pca_pkg::ADDR_W-1:0]    page_address = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [pca_pkg::STATUS_W-1:0]  status;
	logic [pca_pkg::ADDR_W-1:0]    granted_address;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [pca_pkg::CFG_IDX_W-1:0] cfg_index = pca_pkg::CFG_REGION_START;
	logic [pca_pkg::ADDR_W-1:0]    cfg_data = '0;

	free_list_mirror mirror = new();
	int idle_cycles = 0;

	per_cpu_page_free_list_allocator_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.requester(requester),
		.page_address(page_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_address(granted_address),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// result side: stall modes plus two long hold-offs
	initial begin : result_sink
		int seen = 0;
		int hold = 0;
		int mode = 0;
		int mode_left = 0;
		int tick = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && out_ready) begin
					mirror.check_response(status, granted_address);
					seen++;
					if (seen == 300 || seen == 1300) begin
						hold = 500;
					end
				end
				if (hold > 0) begin
					hold--;
					out_ready <= 1'b0;
				end else begin
					if (mode_left == 0) begin
						mode = $urandom_range(0, 3);
						mode_left = $urandom_range(16, 96);
					end
					mode_left--;
					tick++;
					case (mode)
						0: begin
							out_ready <= 1'b1;
						end
						1: begin
							out_ready <= 1'($urandom_range(0, 1));
						end
						2: begin
							out_ready <= (tick % 4 == 0);
						end
						default: begin
							out_ready <= ($urandom_range(0, 9) != 0);
						end
					endcase
				end
			end
		end
	end

	task automatic offer(logic [pca_pkg::KIND_W-1:0] k, logic [pca_pkg::REQ_W-1:0] r,
			logic [pca_pkg::ADDR_W-1:0] a);
		in_valid <= 1'b1;
		kind <= k;
		requester <= r;
		page_address <= a;
		do @(posedge clk); while (!in_ready);
		mirror.note_request(k, r, a);
	endtask

	task automatic rest(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.outstanding() != 0);
	endtask

	task automatic write_register(logic [pca_pkg::CFG_IDX_W-1:0] idx,
			logic [pca_pkg::ADDR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		mirror.set_register(idx, data);
	endtask

	task automatic set_region(logic [pca_pkg::ADDR_W-1:0] start_addr,
			logic [pca_pkg::ADDR_W-1:0] limit_addr, bit poke_spare);
		write_register(pca_pkg::CFG_REGION_START, start_addr);
		write_register(pca_pkg::CFG_REGION_END, limit_addr);
		if (poke_spare) begin
			write_register(CFG_SPARE_A, pca_pkg::ADDR_W'({$urandom, $urandom}));
			write_register(CFG_SPARE_B, pca_pkg::ADDR_W'({$urandom, $urandom}));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_mix(int count);
		int sent, burst, sel;
		logic [pca_pkg::KIND_W-1:0] k;
		logic [pca_pkg::REQ_W-1:0] r;
		logic [pca_pkg::ADDR_W-1:0] a;
		longint unsigned b, pick;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 16);
			while (burst > 0 && sent < count) begin
				b = mirror.base();
				sel = $urandom_range(0, 99);
				pick = $urandom_range(0, 1) ? $urandom_range(0, 63) :
					$urandom_range(0, pca_pkg::NUM_PAGES - 1);
				a = pca_pkg::ADDR_W'(b + pick * pca_pkg::PAGE_BYTES);
				if (sel < 40) begin
					k = pca_pkg::KIND_ALLOC;
					r = pca_pkg::REQ_W'($urandom_range(0, pca_pkg::NUM_REQUESTERS - 1));
					a = pca_pkg::ADDR_W'({$urandom, $urandom});
				end else begin
					k = pca_pkg::KIND_FREE;
					r = pca_pkg::REQ_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) :
						$urandom_range(0, pca_pkg::NUM_REQUESTERS - 1));
					if (sel >= 96) begin
						a = pca_pkg::ADDR_W'(b - $urandom_range(1, 4) * pca_pkg::PAGE_BYTES);
					end else if (sel >= 91) begin
						a = pca_pkg::ADDR_W'({$urandom, $urandom});
					end else if (sel >= 87) begin
						a = a + pca_pkg::ADDR_W'($urandom_range(1, pca_pkg::PAGE_BYTES - 1));
					end else if (sel >= 83) begin
						a = pca_pkg::ADDR_W'(b + (pca_pkg::NUM_PAGES + $urandom_range(0, 15))
							* pca_pkg::PAGE_BYTES);
					end
				end
				offer(k, r, a);
				sent++;
				burst--;
				if (sent % 250 == 0) begin
					drain();
				end
			end
			if (sent < count && $urandom_range(0, 3) != 0) begin
				rest($urandom_range(1, 12));
			end
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bounds, double free, lifo order, single page kept, steals
		offer(pca_pkg::KIND_ALLOC, 3'd0, '0);
		offer(pca_pkg::KIND_FREE, 3'd0, '0);
		offer(pca_pkg::KIND_FREE, 3'd0,
			pca_pkg::ADDR_W'((pca_pkg::NUM_PAGES - 1) * pca_pkg::PAGE_BYTES));
		offer(pca_pkg::KIND_FREE, 3'd0,
			pca_pkg::ADDR_W'(pca_pkg::NUM_PAGES * pca_pkg::PAGE_BYTES));
		offer(pca_pkg::KIND_FREE, 3'd0, pca_pkg::ADDR_W'(pca_pkg::PAGE_BYTES + 1));
		offer(pca_pkg::KIND_FREE, 3'd1, '0);
		offer(pca_pkg::KIND_FREE, 3'd0, pca_pkg::REGION_END_RST);
		offer(pca_pkg::KIND_FREE, 3'd0, '1);
		offer(pca_pkg::KIND_ALLOC, 3'd0, '1);
		offer(pca_pkg::KIND_ALLOC, 3'd1, '0);
		offer(pca_pkg::KIND_ALLOC, 3'd0, '0);
		offer(pca_pkg::KIND_ALLOC, 3'd0, '0);
		for (int i = 5; i <= 9; i++) begin
			offer(pca_pkg::KIND_FREE, 3'd3, pca_pkg::ADDR_W'(i * pca_pkg::PAGE_BYTES));
		end
		offer(pca_pkg::KIND_ALLOC, 3'd1, '0);
		offer(pca_pkg::KIND_ALLOC, 3'd1, '0);
		offer(pca_pkg::KIND_ALLOC, 3'd2, '0);
		offer(pca_pkg::KIND_FREE, 3'd7,
			pca_pkg::REGION_END_RST - pca_pkg::ADDR_W'(pca_pkg::PAGE_BYTES));
		offer(pca_pkg::KIND_ALLOC, 3'd7, '0);
		offer(pca_pkg::KIND_ALLOC, 3'd3, '0);
		offer(pca_pkg::KIND_ALLOC, 3'd3, '0);
		drain();

		run_mix(300);
		set_region(40'h00_1234_5678, 40'h00_1259_E010, 1'b0);
		run_mix(300);
		set_region('0, '1, 1'b1);
		run_mix(300);
		set_region(40'hFF_FFC0_0000, '1, 1'b0);
		run_mix(300);
		// base past the top: every free rejected, listed pages wrap
		set_region('1, '0, 1'b0);
		run_mix(150);
		set_region(40'h00_0000_0001, pca_pkg::REGION_END_RST, 1'b1);
		run_mix(500);

		repeat (64) @(posedge clk);
		if (mirror.errors == 0 && mirror.outstanding() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
